FILE: rtl/mph_pkg.sv
package mph_pkg;

  localparam int VAL_W = 61;
  localparam logic [VAL_W-1:0] PRIME = 61'h1FFF_FFFF_FFFF_FFFF;

  // Command codes on the request channel.
  localparam logic [1:0] CMD_CHUNK  = 2'd0;
  localparam logic [1:0] CMD_LENGTH = 2'd1;
  localparam logic [1:0] CMD_KEY    = 2'd2;

  // Depth of the queue between the front and the back.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_CHUNK,
    OP_FINISH,
    OP_KEY
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [VAL_W-1:0] data;
  } mph_req_t;

  // Maps a 61-bit value into 0..p-1; only p itself is out of range.
  function automatic logic [VAL_W-1:0] fold_canon(input logic [VAL_W-1:0] v);
    fold_canon = (v == PRIME) ? '0 : v;
  endfunction

endpackage

FILE: rtl/mph_front.sv
module mph_front import mph_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  logic [1:0]       cmd,
  input  logic [VAL_W-1:0] data,
  output logic             push_valid,
  input  logic             push_ready,
  output mph_req_t         push_req
);

  logic     fr_valid;
  mph_req_t fr_req;
  logic     dec_ok;
  op_t      dec_op;

  // Unused commands are dropped here and never reach the queue.
  always_comb begin
    dec_ok = 1'b1;
    dec_op = OP_CHUNK;
    case (cmd)
      CMD_CHUNK:  dec_op = OP_CHUNK;
      CMD_LENGTH: dec_op = OP_FINISH;
      CMD_KEY:    dec_op = OP_KEY;
      default:    dec_ok = 1'b0;
    endcase
  end

  assign req_ready  = !fr_valid || push_ready;
  assign push_valid = fr_valid;
  assign push_req   = fr_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (req_ready) begin
      fr_valid <= req_valid && dec_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      fr_req.op   <= dec_op;
      fr_req.data <= fold_canon(data);
    end
  end

endmodule

FILE: rtl/mph_queue.sv
module mph_queue import mph_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  output logic     push_ready,
  input  mph_req_t push_req,
  output logic     pop_valid,
  input  logic     pop_ready,
  output mph_req_t pop_req
);

  mph_req_t           entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_req    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_req;
    end
  end

endmodule

FILE: rtl/mph_back.sv
module mph_back import mph_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  mph_req_t         pop_req,
  input  logic             cfg_we,
  input  logic [VAL_W-1:0] cfg_data,
  output logic             res_valid,
  input  logic             res_ready,
  output logic [VAL_W-1:0] hash_value
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_RED  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_32 = 2'd1;
  localparam logic [1:0] SH_64 = 2'd2;

  localparam int PROD_W = 2 * VAL_W;

  logic [2:0]        state;
  logic [1:0]        idx;
  logic              fin;
  logic [VAL_W-1:0]  accumulator;
  logic [VAL_W-1:0]  current_key;
  logic [VAL_W-1:0]  first_key;
  logic [VAL_W-1:0]  opa;
  logic [63:0]       pp;
  logic [1:0]        pp_sh;
  logic [PROD_W-1:0] prod;
  logic [VAL_W:0]    red;

  logic [VAL_W:0]    sum_raw;
  logic [VAL_W-1:0]  sum_canon;
  logic [31:0]       mul_x;
  logic [31:0]       mul_y;
  logic [PROD_W-1:0] pp_shifted;
  logic [VAL_W:0]    fold_raw;
  logic [VAL_W-1:0]  fold_canon_v;
  logic              fin_go;
  logic              res_load;

  // h + m, both already canonical, so one conditional subtract suffices.
  assign sum_raw   = {1'b0, accumulator} + {1'b0, pop_req.data};
  assign sum_canon = (sum_raw >= {1'b0, PRIME}) ? sum_raw[VAL_W-1:0] - PRIME
                                                : sum_raw[VAL_W-1:0];

  // Partial products: idx bit 1 picks the high half of the sum,
  // idx bit 0 picks the high half of the key.
  assign mul_x = idx[1] ? {3'b000, opa[VAL_W-1:32]} : opa[31:0];
  assign mul_y = idx[0] ? {3'b000, current_key[VAL_W-1:32]} : current_key[31:0];

  always_comb begin
    case (pp_sh)
      SH_0:    pp_shifted = {58'b0, pp};
      SH_32:   pp_shifted = {26'b0, pp, 32'b0};
      SH_64:   pp_shifted = {pp[57:0], 64'b0};
      default: pp_shifted = '0;
    endcase
  end

  // Second fold of the reduced product; the value is at most 2^61.
  assign fold_raw     = {1'b0, red[VAL_W-1:0]} + {{VAL_W{1'b0}}, red[VAL_W]};
  assign fold_canon_v = (fold_raw >= {1'b0, PRIME}) ? fold_raw[VAL_W-1:0] - PRIME
                                                    : fold_raw[VAL_W-1:0];

  assign fin_go    = !fin || !res_valid || res_ready;
  assign pop_ready = (state == ST_IDLE);
  assign res_load  = (state == ST_FIN) && fin && fin_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      idx         <= '0;
      fin         <= 1'b0;
      accumulator <= '0;
      current_key <= '0;
      first_key   <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (res_valid && res_ready && !res_load) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            case (pop_req.op)
              OP_CHUNK, OP_FINISH: begin
                fin   <= (pop_req.op == OP_FINISH);
                idx   <= '0;
                state <= ST_MUL;
              end
              OP_KEY: begin
                current_key <= pop_req.data;
              end
              default: begin
              end
            endcase
          end
        end
        ST_MUL: begin
          idx <= idx + 1'b1;
          if (idx == 2'd3) begin
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          state <= ST_RED;
        end
        ST_RED: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (fin_go) begin
            state <= ST_IDLE;
            if (fin) begin
              res_valid   <= 1'b1;
              accumulator <= '0;
              current_key <= first_key;
            end else begin
              accumulator <= fold_canon_v;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (cfg_we) begin
        first_key   <= fold_canon(cfg_data);
        current_key <= fold_canon(cfg_data);
      end
    end
  end

  // Datapath: the sum, the partial-product pipeline and the reduction.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        opa  <= sum_canon;
        pp   <= '0;
        prod <= '0;
      end
      ST_MUL: begin
        pp    <= mul_x * mul_y;
        pp_sh <= {1'b0, idx[1]} + {1'b0, idx[0]};
        prod  <= prod + pp_shifted;
      end
      ST_ACC: begin
        prod <= prod + pp_shifted;
      end
      ST_RED: begin
        red <= {1'b0, prod[VAL_W-1:0]} + {1'b0, prod[PROD_W-1:VAL_W]};
      end
      ST_FIN: begin
        if (fin && fin_go) begin
          hash_value <= fold_canon_v;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/mersenne61_polynomial_hash_top.sv
// Polynomial hash core over the prime p = 2^61 - 1.
// Requests arrive on the req_valid / req_ready channel with a 2-bit cmd and
// a 61-bit data word. A chunk request (cmd 0) updates h = ((h + m) * key) mod p.
// A length request (cmd 1) absorbs the length the same way, returns the hash
// on the res_valid / res_ready channel, clears h and reloads the key from
// first_key. A key request (cmd 2) loads the segment key; cmd 3 is dropped.
// The user must write first_key through cfg_we / cfg_data only while the core
// is idle (the block does not enforce it); the write also loads the working key.
// The front registers and decodes each request and pushes it into a four-entry
// queue, so req_ready stays high while the back is busy until the queue fills.
// In the back, each chunk or length request passes through the add, the four
// 32x32 partial products on the shared multiplier, a step that sums the last
// one and two steps that reduce mod p. A key request is handled in the idle
// state. res_valid is set with the hash register at the end of the reduction.
// If the receiver stalls, the result waits in the output register; chunks keep
// flowing; a later length request waits for it to drain and blocks the queue.
// Reset is synchronous: h, the working key and first_key go to zero and both
// channels are emptied.
module mersenne61_polynomial_hash_top import mph_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  logic [1:0]       cmd,
  input  logic [VAL_W-1:0] data,
  output logic             res_valid,
  input  logic             res_ready,
  output logic [VAL_W-1:0] hash_value,
  input  logic             cfg_we,
  input  logic [VAL_W-1:0] cfg_data
);

  // Front to queue.
  logic     push_valid;
  logic     push_ready;
  mph_req_t push_req;

  // Queue to back.
  logic     pop_valid;
  logic     pop_ready;
  mph_req_t pop_req;

  mph_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .cmd        (cmd),
    .data       (data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req)
  );

  mph_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_req    (pop_req)
  );

  // The back holds the accumulator, both keys and the result register.
  mph_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_req    (pop_req),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .hash_value (hash_value)
  );

endmodule

FILE: dv/mersenne61_polynomial_hash_top_test.sv
`timescale 1ns / 100ps

// Testbench for the polynomial hash core over p = 2^61 - 1.
//
// Requests are offered on the request channel by one send task, and every
// accepted request is run through a local predictor. The predictor keeps its own
// accumulator, working key and first_key copy. Each length request leaves one
// expected hash in a queue. A checker process compares every hash taken from the
// result channel with the oldest expected one. The test tasks below cover, in
// turn:
//   - the key of zero after reset,
//   - the field extremes and the odd values (p itself, chunks of 2^56 and more,
//     the unused command),
//   - a first_key write in the middle of a message,
//   - a long stall on the result side that backs the queue up to the input,
//   - a long run of random messages under several first_key settings.
module mersenne61_polynomial_hash_top_test;
  import mph_pkg::*;

  // The package names three commands; the fourth code is dropped by the block.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Cycles to let pass once nothing is expected any more: enough for a full
  // queue of four chunk requests to drain through the back.
  localparam int SETTLE_CYCLES = 64;
  localparam int ITEM_TARGET = 1450;
  localparam int HOLD_CYCLES = 400;
  localparam logic [VAL_W-1:0] CHUNK_MAX = (61'd1 << 56) - 61'd1;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_ready;
  logic [1:0]       cmd = CMD_CHUNK;
  logic [VAL_W-1:0] data = '0;
  logic             res_valid;
  logic             res_ready = 1'b0;
  logic [VAL_W-1:0] hash_value;
  logic             cfg_we = 1'b0;
  logic [VAL_W-1:0] cfg_data = '0;

  mersenne61_polynomial_hash_top dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .cmd        (cmd),
    .data       (data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .hash_value (hash_value),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: the running hash, the key of the current segment and the
  // key that every new message starts with.
  logic [VAL_W-1:0] hash_acc = '0;
  logic [VAL_W-1:0] segment_key = '0;
  logic [VAL_W-1:0] start_key = '0;
  logic [VAL_W-1:0] pending_hashes[$];

  int fail_count = 0;
  int sent_items = 0;
  // While quiet is set neither side inserts gaps.
  bit quiet = 1'b0;
  // Set by a test to make the receiver hold off for a long stretch.
  bit hold_request = 1'b0;

  // Reduces any value below 2^122 to 0..p-1. Folding the bits above 61 back
  // onto the low part works because 2^61 is 1 mod p.
  function automatic logic [VAL_W-1:0] reduce_mod_p(input logic [2*VAL_W-1:0] v);
    logic [VAL_W:0] t;
    t = {1'b0, v[VAL_W-1:0]} + {1'b0, v[2*VAL_W-1:VAL_W]};
    t = {1'b0, t[VAL_W-1:0]} + {{VAL_W{1'b0}}, t[VAL_W]};
    if (t >= {1'b0, PRIME})
      t = t - {1'b0, PRIME};
    return t[VAL_W-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] canon(input logic [VAL_W-1:0] v);
    return reduce_mod_p({{VAL_W{1'b0}}, v});
  endfunction

  // One step of the hash recurrence: h = ((h + m) * key) mod p.
  function automatic logic [VAL_W-1:0] hash_step(input logic [VAL_W-1:0] h,
                                                 input logic [VAL_W-1:0] m,
                                                 input logic [VAL_W-1:0] k);
    logic [VAL_W-1:0]   sum;
    logic [2*VAL_W-1:0] prod;
    sum = reduce_mod_p({{VAL_W{1'b0}}, h} + {{VAL_W{1'b0}}, canon(m)});
    prod = {{VAL_W{1'b0}}, sum} * {{VAL_W{1'b0}}, k};
    return reduce_mod_p(prod);
  endfunction

  // Applies one accepted request to the predictor.
  task automatic predict_request(input logic [1:0] c, input logic [VAL_W-1:0] d);
    case (c)
      CMD_CHUNK: begin
        hash_acc = hash_step(hash_acc, d, segment_key);
      end
      CMD_LENGTH: begin
        pending_hashes.push_back(hash_step(hash_acc, d, segment_key));
        hash_acc = '0;
        segment_key = canon(start_key);
      end
      CMD_KEY: begin
        segment_key = canon(d);
      end
      default: begin
      end
    endcase
  endtask

  // Gap before a request or after a result: mostly none, sometimes a short
  // one, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet)
      return 0;
    if (r < 60)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    if (r < 98)
      return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [VAL_W-1:0] rand61();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[VAL_W-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] random_key();
    int r;
    r = $urandom_range(0, 19);
    if (r < 2)
      return PRIME;
    if (r < 4)
      return PRIME - 61'd1;
    if (r == 4)
      return '0;
    return rand61();
  endfunction

  function automatic logic [VAL_W-1:0] random_chunk();
    int r;
    r = $urandom_range(0, 19);
    if (r < 16)
      return rand61() & CHUNK_MAX;
    if (r < 18)
      return rand61();
    if (r == 18)
      return CHUNK_MAX;
    return PRIME - 61'd1;
  endfunction

  // Offers one request and returns at the edge where it is taken. It is
  // always entered at a rising edge, so all drives below are edge aligned.
  task automatic send_request(input logic [1:0] c, input logic [VAL_W-1:0] d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    cmd <= c;
    data <= d;
    do
      @(posedge clk);
    while (!req_ready);
    predict_request(c, d);
    if (c != CMD_UNUSED)
      sent_items++;
  endtask

  // Waits until every expected hash has come back and the back has had time
  // to finish any chunk still in flight.
  task automatic wait_idle();
    req_valid <= 1'b0;
    while (pending_hashes.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes first_key; the block also loads it as the working key. Only called
  // from an idle state.
  task automatic write_start_key(input logic [VAL_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    start_key = v;
    segment_key = canon(v);
  endtask

  // Receiver: random stalls, plus the long hold that a test can ask for.
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    while (rst)
      @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        res_ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        res_ready <= 1'b0;
        stall_left--;
      end else begin
        res_ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Result checker: values seen here are those from just before the edge.
  always @(posedge clk) begin
    logic [VAL_W-1:0] want;
    if (!rst && res_valid && res_ready) begin
      if (pending_hashes.size() == 0) begin
        $display("%0t: hash with no length request pending, expected none, actual %h",
                 $time, hash_value);
        fail_count++;
      end else begin
        want = pending_hashes.pop_front();
        if (hash_value !== want) begin
          $display("%0t: hash_value mismatch, expected %h, actual %h",
                   $time, want, hash_value);
          fail_count++;
        end
      end
    end
  end

  // After reset first_key is zero, so every message must hash to zero.
  task automatic test_reset_key_zero();
    send_request(CMD_CHUNK, rand61() & CHUNK_MAX);
    send_request(CMD_CHUNK, CHUNK_MAX);
    send_request(CMD_LENGTH, 61'd14);
    wait_idle();
  endtask

  // Field extremes, values equal to p, oversized chunks and the unused command.
  task automatic test_directed_edges();
    write_start_key(PRIME - 61'd1);
    send_request(CMD_CHUNK, '0);
    send_request(CMD_CHUNK, CHUNK_MAX);
    send_request(CMD_CHUNK, 61'd1 << 56);
    send_request(CMD_CHUNK, PRIME);
    send_request(CMD_CHUNK, PRIME - 61'd1);
    send_request(CMD_LENGTH, 61'd35);
    // A key of p reduces to zero, which wipes the running hash.
    send_request(CMD_KEY, PRIME);
    send_request(CMD_CHUNK, rand61());
    send_request(CMD_UNUSED, PRIME);
    send_request(CMD_LENGTH, 61'd7);
    send_request(CMD_KEY, PRIME - 61'd1);
    send_request(CMD_CHUNK, PRIME - 61'd1);
    send_request(CMD_KEY, 61'd1);
    send_request(CMD_CHUNK, CHUNK_MAX);
    send_request(CMD_LENGTH, PRIME);
    // An empty message, then one with a zero key and the largest length.
    send_request(CMD_LENGTH, '0);
    send_request(CMD_KEY, '0);
    send_request(CMD_LENGTH, PRIME - 61'd1);
    wait_idle();
  endtask

  // A first_key write while a message is half absorbed changes the working key
  // but must leave the running hash alone.
  task automatic test_mid_message_key_write();
    write_start_key(61'd1);
    send_request(CMD_CHUNK, rand61() & CHUNK_MAX);
    send_request(CMD_CHUNK, rand61() & CHUNK_MAX);
    wait_idle();
    write_start_key(rand61() & (PRIME - 61'd1));
    send_request(CMD_CHUNK, rand61() & CHUNK_MAX);
    send_request(CMD_LENGTH, 61'd21);
    wait_idle();
  endtask

  // The receiver holds off while short messages keep coming, so the output
  // register fills, the next length request waits and the queue backs up
  // into the request channel.
  task automatic test_output_backpressure();
    int i;
    quiet = 1'b1;
    hold_request = 1'b1;
    for (i = 0; i < 12; i++) begin
      send_request(CMD_CHUNK, random_chunk());
      send_request(CMD_LENGTH, 61'($urandom_range(1, 7)));
    end
    quiet = 1'b0;
    wait_idle();
  endtask

  // One well formed message with random content: an optional segment key,
  // chunks with a key reload every few chunks, some unused-command noise,
  // and a length request that mostly matches the chunk count.
  task automatic send_random_message();
    int n_chunks;
    int seg;
    int i;
    int r;
    int byte_len;
    r = $urandom_range(0, 99);
    if (r < 10)
      n_chunks = 0;
    else if (r < 85)
      n_chunks = $urandom_range(1, 8);
    else if (r < 97)
      n_chunks = $urandom_range(9, 24);
    else
      n_chunks = $urandom_range(25, 60);
    seg = $urandom_range(2, 12);
    if ($urandom_range(0, 3) == 0)
      send_request(CMD_KEY, random_key());
    for (i = 0; i < n_chunks; i++) begin
      if (i > 0 && i % seg == 0)
        send_request(CMD_KEY, random_key());
      if ($urandom_range(0, 39) == 0)
        send_request(CMD_UNUSED, rand61());
      send_request(CMD_CHUNK, random_chunk());
    end
    byte_len = 7 * n_chunks - $urandom_range(0, 6);
    if (byte_len < 0)
      byte_len = 0;
    if ($urandom_range(0, 9) == 0)
      send_request(CMD_LENGTH, rand61());
    else
      send_request(CMD_LENGTH, 61'(byte_len));
  endtask

  // Random messages in phases; between phases first_key moves through its
  // extremes and random values.
  task automatic test_random_messages();
    int msgs;
    int r;
    logic [VAL_W-1:0] k;
    msgs = 0;
    while (sent_items < ITEM_TARGET) begin
      if (msgs % 25 == 0) begin
        wait_idle();
        r = $urandom_range(0, 5);
        if (r == 0)
          k = '0;
        else if (r == 1)
          k = 61'd1;
        else if (r == 2)
          k = PRIME - 61'd1;
        else
          k = rand61();
        if (k == PRIME)
          k = PRIME - 61'd1;
        write_start_key(k);
      end
      quiet = ($urandom_range(0, 7) == 0);
      send_random_message();
      msgs++;
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_key_zero();
    test_directed_edges();
    test_mid_message_key_write();
    test_output_backpressure();
    test_random_messages();
    wait_idle();
    if (fail_count == 0)
      $display("mersenne61_polynomial_hash_top_test OK");
    else
      $display("mersenne61_polynomial_hash_top_test NOT OK");
    $finish;
  end

  // Watchdog: a run that has not finished by this point is reported as failed.
  initial begin
    #4000000;
    $display("mersenne61_polynomial_hash_top_test NOT OK");
    $finish;
  end

endmodule
